FILE: rtl/prdc_pkg.sv
`timescale 1ns / 1ps

package prdc_pkg;

  // Default sizing of the block.
  localparam int DEFAULT_PAGE_BYTES   = 4096;
  localparam int DEFAULT_COUNTER_BITS = 48;
  localparam int DEFAULT_SIZE_BITS    = 40;

  // Fixed field widths.
  localparam int THRESH_W   = 14;
  localparam int RATIO_W    = 17;
  localparam int QUO_W      = 33;
  localparam int MUL_B_W    = 34;
  localparam int ACC_W      = 35;
  localparam int OUTCOME_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_SHIFT = 16;

  // Q16.16 one and the saturated ratio.
  localparam logic [QUO_W-1:0] ONE_Q16   = 33'h0_0001_0000;
  localparam logic [QUO_W-1:0] RATIO_CAP = 33'h1_0000_0000;

  // Outcome codes.
  localparam logic [OUTCOME_W-1:0] OC_BELOW_FLOOR = 3'd0;
  localparam logic [OUTCOME_W-1:0] OC_PRESSURE    = 3'd1;
  localparam logic [OUTCOME_W-1:0] OC_ADVICE_ZERO = 3'd2;
  localparam logic [OUTCOME_W-1:0] OC_BELOW_MIN   = 3'd3;
  localparam logic [OUTCOME_W-1:0] OC_ISSUED      = 3'd4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRACTION   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_TARGET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EFF_TARGET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MAX   = 3'd6;

  // Register reset values.
  localparam logic [THRESH_W-1:0] RST_THRESHOLD  = 14'd1000;
  localparam logic [RATIO_W-1:0]  RST_FRACTION   = 17'd6554;
  localparam logic [RATIO_W-1:0]  RST_ACC_TARGET = 17'd32768;
  localparam logic [RATIO_W-1:0]  RST_EFF_TARGET = 17'd6554;
  localparam longint RST_STEP_MIN = 4096;
  localparam longint RST_STEP_MAX = 1073741824;

endpackage

FILE: rtl/prdc_div.sv
`timescale 1ns / 1ps

module prdc_div import prdc_pkg::*; #(
  parameter int NW = 65,
  parameter int DW = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NW-1:0]    num,
  input  logic [DW-1:0]    den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] nsh;
  logic [NW-1:0] q;
  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   shifted;
  logic          ge;
  logic [DW:0]   diff;

  // One restoring step: bring down the next numerator bit and try a subtract.
  always_comb begin
    shifted = {rem, nsh[NW-1]};
    ge      = (shifted >= {1'b0, dreg});
    diff    = shifted - {1'b0, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= num;
      dreg <= den;
      rem  <= '0;
      q    <= '0;
    end else if (busy) begin
      nsh <= nsh << 1;
      q   <= {q[NW-2:0], ge};
      rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
    end
  end

  // Quotients of 2^32 or more saturate at 2^32.
  assign quo = (q[NW-1:32] != '0) ? RATIO_CAP : {1'b0, q[31:0]};

endmodule

FILE: rtl/prdc_mul.sv
`timescale 1ns / 1ps

module prdc_mul import prdc_pkg::*; #(
  parameter int AW = 40
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [AW-1:0]      a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [AW-1:0]      prod
);

  localparam int PW = AW + MUL_B_W;
  localparam int CW = $clog2(MUL_B_W + 1);

  logic [PW-1:0]      acc;
  logic [PW-1:0]      ash;
  logic [MUL_B_W-1:0] bsh;
  logic [CW-1:0]      cnt;
  logic               busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(MUL_B_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift-and-add, one multiplier bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      ash <= PW'(a);
      bsh <= b;
    end else if (busy) begin
      if (bsh[0]) begin
        acc <= acc + ash;
      end
      ash <= ash << 1;
      bsh <= bsh >> 1;
    end
  end

  // Drop the Q16 fraction and saturate to the size width.
  assign prod = (acc[PW-1:AW+FRAC_SHIFT] != '0) ? '1 : acc[AW+FRAC_SHIFT-1:FRAC_SHIFT];

endmodule

FILE: rtl/pressure_driven_reclaim_controller.sv
`timescale 1ns / 1ps

// Pressure-driven reclaim controller. Each request carries memory use, a
// pressure reading and four cumulative reclaim counters, and yields one
// page-aligned reclaim size with an outcome code. A request that stops at the
// floor or pressure check goes from the check state straight to the finish
// state; one that goes through the full correction uses the bit-serial
// divider (up to three quotients) and the shift-add multiplier (up to three
// products), which run one after the other under the sequencer. in_ready is
// high only while no request is in work; a finished result waits in the
// output register and the next request is taken meanwhile. Configuration
// writes take effect at once and should be made while the block is idle.
module pressure_driven_reclaim_controller import prdc_pkg::*; #(
  parameter int PAGE_BYTES   = DEFAULT_PAGE_BYTES,
  parameter int COUNTER_BITS = DEFAULT_COUNTER_BITS,
  parameter int SIZE_BITS    = DEFAULT_SIZE_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [SIZE_BITS-1:0]    cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SIZE_BITS-1:0]    usage_bytes,
  input  logic [THRESH_W-1:0]     pressure_level,
  input  logic [COUNTER_BITS-1:0] scanned_total,
  input  logic [COUNTER_BITS-1:0] stolen_total,
  input  logic [COUNTER_BITS-1:0] anon_refault_total,
  input  logic [COUNTER_BITS-1:0] file_refault_total,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SIZE_BITS-1:0]    reclaim_bytes,
  output logic [OUTCOME_W-1:0]    outcome
);

  localparam int S          = SIZE_BITS;
  localparam int C          = COUNTER_BITS;
  localparam int NW         = C + 1 + FRAC_SHIFT;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHECK  = 4'd1;
  localparam logic [3:0] ST_HEAD   = 4'd2;
  localparam logic [3:0] ST_FACT   = 4'd3;
  localparam logic [3:0] ST_SIZE   = 4'd4;
  localparam logic [3:0] ST_DELTA  = 4'd5;
  localparam logic [3:0] ST_BRANCH = 4'd6;
  localparam logic [3:0] ST_RACC   = 4'd7;
  localparam logic [3:0] ST_REFF   = 4'd8;
  localparam logic [3:0] ST_CORR   = 4'd9;
  localparam logic [3:0] ST_LIMIT  = 4'd10;
  localparam logic [3:0] ST_FINISH = 4'd11;

  // Configuration registers.
  logic [THRESH_W-1:0] pressure_threshold;
  logic [RATIO_W-1:0]  reclaim_fraction;
  logic [RATIO_W-1:0]  accuracy_target;
  logic [RATIO_W-1:0]  efficiency_target;
  logic [S-1:0]        usage_floor;
  logic [S-1:0]        step_minimum;
  logic [S-1:0]        step_maximum;

  // Stored counters from the previous read.
  logic [C-1:0] previous_scanned;
  logic [C-1:0] previous_stolen;
  logic [C-1:0] previous_anon_refaults;
  logic [C-1:0] previous_file_refaults;

  // Latched request.
  logic [S-1:0]        use_r;
  logic [THRESH_W-1:0] p_r;
  logic [C-1:0]        scan_c;
  logic [C-1:0]        steal_c;
  logic [C-1:0]        anon_c;
  logic [C-1:0]        file_c;

  // Working registers.
  logic [3:0]             state;
  logic [S-1:0]           size;
  logic [S-1:0]           res;
  logic [OUTCOME_W-1:0]   oc;
  logic [C-1:0]           scan_d;
  logic                   scan_n;
  logic [C-1:0]           steal_d;
  logic                   steal_n;
  logic [C:0]             rmag;
  logic                   r_n;
  logic signed [ACC_W-1:0] acc;

  // Shared unit handshakes.
  logic               div_start;
  logic [NW-1:0]      div_num;
  logic [C-1:0]       div_den;
  logic               div_done;
  logic [QUO_W-1:0]   div_q;
  logic               mul_start;
  logic [S-1:0]       mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_done;
  logic [S-1:0]       mul_p;

  // Deltas of the counters as sign and magnitude.
  logic [C-1:0] scan_raw, steal_raw, anon_raw, file_raw;
  logic [C-1:0] scan_mag, steal_mag, anon_mag, file_mag;
  logic [C:0]   rmag_next;
  logic         r_n_next;
  logic signed [ACC_W-1:0] acc_next;
  logic         acc_low, eff_low;
  logic [S-1:0] capped;

  always_comb begin
    scan_raw  = scan_c - previous_scanned;
    steal_raw = steal_c - previous_stolen;
    anon_raw  = anon_c - previous_anon_refaults;
    file_raw  = file_c - previous_file_refaults;
    scan_mag  = scan_raw[C-1] ? (~scan_raw + 1'b1) : scan_raw;
    steal_mag = steal_raw[C-1] ? (~steal_raw + 1'b1) : steal_raw;
    anon_mag  = anon_raw[C-1] ? (~anon_raw + 1'b1) : anon_raw;
    file_mag  = file_raw[C-1] ? (~file_raw + 1'b1) : file_raw;
    if (anon_raw[C-1] == file_raw[C-1]) begin
      r_n_next  = anon_raw[C-1];
      rmag_next = {1'b0, anon_mag} + {1'b0, file_mag};
    end else if (anon_mag >= file_mag) begin
      r_n_next  = anon_raw[C-1];
      rmag_next = {1'b0, anon_mag - file_mag};
    end else begin
      r_n_next  = file_raw[C-1];
      rmag_next = {1'b0, file_mag - anon_mag};
    end
  end

  // Accuracy from the refault ratio, and the two target checks.
  always_comb begin
    acc_next = r_n ? $signed({2'b00, ONE_Q16} + {2'b00, div_q})
                   : $signed({2'b00, ONE_Q16} - {2'b00, div_q});
    acc_low  = (acc < $signed({{(ACC_W-RATIO_W){1'b0}}, accuracy_target}));
    eff_low  = (div_q < {{(QUO_W-RATIO_W){1'b0}}, efficiency_target});
    capped   = (size > step_maximum) ? step_maximum : size;
  end

  assign in_ready = (state == ST_IDLE);

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_threshold <= RST_THRESHOLD;
      reclaim_fraction   <= RST_FRACTION;
      accuracy_target    <= RST_ACC_TARGET;
      efficiency_target  <= RST_EFF_TARGET;
      usage_floor        <= '0;
      step_minimum       <= S'(RST_STEP_MIN);
      step_maximum       <= S'(RST_STEP_MAX);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:  pressure_threshold <= cfg_data[THRESH_W-1:0];
        REG_FRACTION:   reclaim_fraction   <= cfg_data[RATIO_W-1:0];
        REG_ACC_TARGET: accuracy_target    <= cfg_data[RATIO_W-1:0];
        REG_EFF_TARGET: efficiency_target  <= cfg_data[RATIO_W-1:0];
        REG_FLOOR:      usage_floor        <= cfg_data;
        REG_STEP_MIN:   step_minimum       <= cfg_data;
        REG_STEP_MAX:   step_maximum       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      mul_start <= 1'b0;
      previous_scanned       <= '0;
      previous_stolen        <= '0;
      previous_anon_refaults <= '0;
      previous_file_refaults <= '0;
    end else begin
      div_start <= 1'b0;
      mul_start <= 1'b0;
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            use_r   <= usage_bytes;
            p_r     <= pressure_level;
            scan_c  <= scanned_total;
            steal_c <= stolen_total;
            anon_c  <= anon_refault_total;
            file_c  <= file_refault_total;
            state   <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          res <= '0;
          if (use_r < usage_floor) begin
            oc    <= OC_BELOW_FLOOR;
            state <= ST_FINISH;
          end else if (p_r >= pressure_threshold) begin
            oc    <= OC_PRESSURE;
            state <= ST_FINISH;
          end else begin
            div_num   <= NW'({pressure_threshold - p_r, 16'b0});
            div_den   <= C'(pressure_threshold);
            div_start <= 1'b1;
            state     <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          if (div_done) begin
            mul_a     <= S'(div_q[RATIO_W-1:0]);
            mul_b     <= MUL_B_W'(reclaim_fraction);
            mul_start <= 1'b1;
            state     <= ST_FACT;
          end
        end
        ST_FACT: begin
          if (mul_done) begin
            mul_a     <= use_r;
            mul_b     <= MUL_B_W'(mul_p[RATIO_W-1:0]);
            mul_start <= 1'b1;
            state     <= ST_SIZE;
          end
        end
        ST_SIZE: begin
          if (mul_done) begin
            size <= mul_p;
            if (mul_p == '0) begin
              oc    <= OC_ADVICE_ZERO;
              state <= ST_FINISH;
            end else begin
              state <= ST_DELTA;
            end
          end
        end
        ST_DELTA: begin
          scan_d  <= scan_mag;
          scan_n  <= scan_raw[C-1];
          steal_d <= steal_mag;
          steal_n <= steal_raw[C-1];
          rmag    <= rmag_next;
          r_n     <= r_n_next;
          previous_scanned       <= scan_c;
          previous_stolen        <= steal_c;
          previous_anon_refaults <= anon_c;
          previous_file_refaults <= file_c;
          state   <= ST_BRANCH;
        end
        ST_BRANCH: begin
          if (!steal_n && steal_d != '0 && !scan_n && scan_d != '0) begin
            div_num   <= {rmag, 16'b0};
            div_den   <= steal_d;
            div_start <= 1'b1;
            state     <= ST_RACC;
          end else if (steal_d == '0 && scan_d == '0) begin
            mul_a     <= size;
            mul_b     <= MUL_B_W'(accuracy_target);
            mul_start <= 1'b1;
            state     <= ST_CORR;
          end else begin
            state <= ST_LIMIT;
          end
        end
        ST_RACC: begin
          if (div_done) begin
            acc       <= acc_next;
            div_num   <= NW'({steal_d, 16'b0});
            div_den   <= scan_d;
            div_start <= 1'b1;
            state     <= ST_REFF;
          end
        end
        ST_REFF: begin
          if (div_done) begin
            if (acc_low || eff_low) begin
              if (acc <= 0) begin
                size  <= '0;
                state <= ST_LIMIT;
              end else begin
                mul_a     <= size;
                mul_b     <= acc[MUL_B_W-1:0];
                mul_start <= 1'b1;
                state     <= ST_CORR;
              end
            end else begin
              state <= ST_LIMIT;
            end
          end
        end
        ST_CORR: begin
          if (mul_done) begin
            size  <= mul_p;
            state <= ST_LIMIT;
          end
        end
        ST_LIMIT: begin
          if (size == '0 || size < step_minimum) begin
            res <= '0;
            oc  <= OC_BELOW_MIN;
          end else begin
            res <= capped & ({S{1'b1}} << PAGE_SHIFT);
            oc  <= OC_ISSUED;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          // Hand the result to the output register once it is free.
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            reclaim_bytes <= res;
            outcome       <= oc;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  prdc_div #(
    .NW(NW),
    .DW(C)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  prdc_mul #(
    .AW(S)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

endmodule
